[rtl/core/afbs_pkg.sv]
// Shared types and constants for the Annex B frame boundary splitter.
// Used by the parser, the result queue and the top level.
package afbs_pkg;

    localparam int LEN_BITS     = 32;
    localparam int TYPE_BITS    = 5;
    localparam int WINDOW_DEPTH = 5;
    localparam int FILL_BITS    = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = 2;
    localparam int QCNT_BITS    = 3;

    // Low five bits of the header byte carry the unit type
    localparam logic [7:0] TYPE_MASK = 8'h1f;
    // Top bit of the first slice byte: first macroblock address coded as zero
    localparam logic [7:0] FIRST_MB_ZERO_BIT = 8'h80;

    // NAL unit type codes
    localparam logic [TYPE_BITS-1:0] NAL_UNSPEC = 5'd0;
    localparam logic [TYPE_BITS-1:0] NAL_SLICE  = 5'd1;
    localparam logic [TYPE_BITS-1:0] NAL_IDR    = 5'd5;
    localparam logic [TYPE_BITS-1:0] NAL_SEI    = 5'd6;
    localparam logic [TYPE_BITS-1:0] NAL_SPS    = 5'd7;
    localparam logic [TYPE_BITS-1:0] NAL_PPS    = 5'd8;

    // One result word
    typedef struct packed {
        logic [LEN_BITS-1:0] frame_length;
        logic                is_final;
        logic                last_of_run;
    } result_t;

    // Results produced by one input word, handed to the queue
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[rtl/core/annexb_frame_boundary_splitter.sv]
// Top level of the Annex B frame boundary splitter.
// Depends on afbs_pkg, afbs_parser and afbs_result_queue.

// Takes one stream byte per cycle while the output queue has room, and
// reports each frame's length in bytes when the next frame's first unit is
// recognized, plus a final length on the byte flagged end_of_stream (after
// which the block starts a fresh stream). A byte is processed in the cycle it
// is accepted; its results are registered in a four-entry output queue before
// they reach the output. A byte yields zero, one or two results; input is
// taken whenever the queue has space for two, so with the output always ready
// the sustained rate is one byte per cycle.
module annexb_frame_boundary_splitter #(
    parameter int POSITION_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_stream,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [afbs_pkg::LEN_BITS-1:0] frame_length,
    output logic                          is_final,
    output logic                          last_of_run
);

    logic              accept;
    afbs_pkg::push_t   push;
    afbs_pkg::result_t head;

    assign accept = in_valid && in_ready;

    // Parse the byte stream
    afbs_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .push          (push)
    );

    // Queue results toward the output
    afbs_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign frame_length = head.frame_length;
    assign is_final     = head.is_final;
    assign last_of_run  = head.last_of_run;

    // A flush word always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_stream) |=> out_valid)
        else $error("flush word produced no result");

    // The final length always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_final) |-> last_of_run)
        else $error("final length not marked last of run");

    // Input stalls only when results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty queue");

endmodule

[rtl/core/afbs_parser.sv]
// Start code window, unit type tracking and frame length computation.
// Depends on afbs_pkg; produces up to two result words per input word.
module afbs_parser #(
    parameter int POSITION_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             end_of_stream,
    output afbs_pkg::push_t  push
);

    localparam int PB = POSITION_BITS;
    localparam int DW = (PB > afbs_pkg::LEN_BITS) ? PB : afbs_pkg::LEN_BITS;

    logic [7:0]                        window_reg [afbs_pkg::WINDOW_DEPTH];
    logic [7:0]                        window_next [afbs_pkg::WINDOW_DEPTH];
    logic [afbs_pkg::FILL_BITS-1:0]    fill_reg, fill_next;
    logic [PB-1:0]                     pos_reg, pos_next;
    logic [PB-1:0]                     start_reg, start_next;
    logic [afbs_pkg::TYPE_BITS-1:0]    prev_type_reg, prev_type_next;

    logic                              code_seen;
    logic [afbs_pkg::TYPE_BITS-1:0]    unit_type;
    logic [PB-1:0]                     unit_pos;
    logic                              prev_vcl;
    logic                              cut;
    logic [PB-1:0]                     start_after_cut;
    logic [PB-1:0]                     cut_diff;
    logic [PB-1:0]                     final_diff;
    logic [DW-1:0]                     cut_wide;
    logic [DW-1:0]                     final_wide;
    logic [afbs_pkg::LEN_BITS-1:0]     cut_len;
    logic [afbs_pkg::LEN_BITS-1:0]     final_len;

    // Detect 00 00 00 01 followed by the header byte
    assign code_seen = (fill_reg == afbs_pkg::FILL_BITS'(afbs_pkg::WINDOW_DEPTH))
                    && (window_reg[0] == 8'h00) && (window_reg[1] == 8'h00)
                    && (window_reg[2] == 8'h00) && (window_reg[3] == 8'h01);
    assign unit_type = afbs_pkg::TYPE_BITS'(window_reg[4] & afbs_pkg::TYPE_MASK);
    assign unit_pos  = (pos_reg >= PB'(afbs_pkg::WINDOW_DEPTH))
                     ? pos_reg - PB'(afbs_pkg::WINDOW_DEPTH) : '0;
    assign prev_vcl  = (prev_type_reg >= afbs_pkg::NAL_SLICE)
                    && (prev_type_reg <= afbs_pkg::NAL_IDR);

    // Decide whether this unit opens a new frame
    always_comb
    begin
        cut = 1'b0;
        if (code_seen)
        begin
            priority if ((unit_type == afbs_pkg::NAL_SLICE) || (unit_type == afbs_pkg::NAL_IDR))
            begin
                if (unit_type != prev_type_reg)
                    cut = prev_vcl;
                else
                    cut = (data_byte & afbs_pkg::FIRST_MB_ZERO_BIT) != 8'h00;
            end
            else if ((unit_type == afbs_pkg::NAL_SEI) || (unit_type == afbs_pkg::NAL_SPS)
                     || (unit_type == afbs_pkg::NAL_PPS))
            begin
                cut = prev_vcl;
            end
            else
            begin
                cut = 1'b0;
            end
        end
    end

    // Advance position, saturating at the top
    assign pos_next        = (pos_reg == {PB{1'b1}}) ? pos_reg : pos_reg + PB'(1);
    assign start_after_cut = cut ? unit_pos : start_reg;

    // Lengths, floored at zero and clamped to the output width
    assign cut_diff   = (unit_pos > start_reg) ? unit_pos - start_reg : '0;
    assign final_diff = (pos_next > start_after_cut) ? pos_next - start_after_cut : '0;
    assign cut_wide   = DW'(cut_diff);
    assign final_wide = DW'(final_diff);
    assign cut_len    = (cut_wide > DW'({afbs_pkg::LEN_BITS{1'b1}}))
                      ? {afbs_pkg::LEN_BITS{1'b1}} : cut_wide[afbs_pkg::LEN_BITS-1:0];
    assign final_len  = (final_wide > DW'({afbs_pkg::LEN_BITS{1'b1}}))
                      ? {afbs_pkg::LEN_BITS{1'b1}} : final_wide[afbs_pkg::LEN_BITS-1:0];

    // Pack the results of this word, boundary first and flush last
    always_comb
    begin
        push = '0;
        push.count = {1'b0, cut} + {1'b0, end_of_stream};
        if (cut)
        begin
            push.first.frame_length = cut_len;
            push.first.is_final     = 1'b0;
            push.first.last_of_run  = !end_of_stream;
            push.second.frame_length = final_len;
            push.second.is_final     = 1'b1;
            push.second.last_of_run  = 1'b1;
        end
        else
        begin
            push.first.frame_length = final_len;
            push.first.is_final     = 1'b1;
            push.first.last_of_run  = 1'b1;
        end
    end

    // Next state: shift the window, track type and frame start, clear on flush
    always_comb
    begin
        for (int k = 0; k < afbs_pkg::WINDOW_DEPTH - 1; k++)
            window_next[k] = window_reg[k + 1];
        window_next[afbs_pkg::WINDOW_DEPTH - 1] = data_byte;
        fill_next = (fill_reg < afbs_pkg::FILL_BITS'(afbs_pkg::WINDOW_DEPTH))
                  ? fill_reg + afbs_pkg::FILL_BITS'(1) : fill_reg;
        prev_type_next = (code_seen && (unit_type != afbs_pkg::NAL_UNSPEC))
                       ? unit_type : prev_type_reg;
        start_next = start_after_cut;
        if (end_of_stream)
        begin
            for (int k = 0; k < afbs_pkg::WINDOW_DEPTH; k++)
                window_next[k] = 8'h00;
            fill_next      = '0;
            prev_type_next = afbs_pkg::NAL_UNSPEC;
            start_next     = '0;
        end
    end

    // Hold state, update on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < afbs_pkg::WINDOW_DEPTH; k++)
                window_reg[k] <= 8'h00;
            fill_reg      <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            prev_type_reg <= afbs_pkg::NAL_UNSPEC;
        end
        else if (accept)
        begin
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            pos_reg       <= end_of_stream ? '0 : pos_next;
            start_reg     <= start_next;
            prev_type_reg <= prev_type_next;
        end
    end

endmodule

[rtl/core/afbs_result_queue.sv]
// Four-entry result queue that takes up to two words per cycle.
// Depends on afbs_pkg; drives the output channel.
module afbs_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  afbs_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output afbs_pkg::result_t head
);

    afbs_pkg::result_t                 mem_reg [afbs_pkg::QUEUE_DEPTH];
    logic [afbs_pkg::QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [afbs_pkg::QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [afbs_pkg::QCNT_BITS-1:0]    count_reg, count_next;
    logic [1:0]                        push_n;
    logic                              pop;

    // Room for two words keeps a two-result word from overflowing
    assign room      = count_reg <= afbs_pkg::QCNT_BITS'(afbs_pkg::QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_n    = push_en ? push.count : 2'd0;

    assign wr_ptr_next = wr_ptr_reg + afbs_pkg::QPTR_BITS'(push_n);
    assign rd_ptr_next = rd_ptr_reg + afbs_pkg::QPTR_BITS'(pop);
    assign count_next  = count_reg + afbs_pkg::QCNT_BITS'(push_n)
                       - afbs_pkg::QCNT_BITS'(pop);

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push_n == 2'd2)
            mem_reg[wr_ptr_reg + afbs_pkg::QPTR_BITS'(1)] <= push.second;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
